### sv/sfr_pkg.sv
package sfr_pkg;

    // Byte lanes held by the key and value registers
    localparam int LANES    = 8;
    localparam int BYTE_W   = 8;
    localparam int REG_W    = LANES * BYTE_W;
    localparam int LEN_W    = 4;
    localparam int CNT_W    = 16;
    localparam int PTR_W    = 3;
    localparam int CFG_IDX_W = 2;

    // Saturation limit of the replacement counter
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_BYTES  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_LENGTH = 2'd3;

    // Everything one input byte produces, in emit order
    typedef struct packed {
        logic [LANES-1:0][BYTE_W-1:0] bytes;   // lane 0 goes out first
        logic [LEN_W-1:0]             count;   // number of results, 0..8
        logic                         marker;  // single empty end marker
        logic                         fin;     // stream ends with this batch
        logic [CNT_W-1:0]             total;   // replacement count at stream end
        logic                         found;   // at least one replacement
    } sfr_step_t;

endpackage

### sv/sfr_match.sv
// Match window and counters. Works out the whole batch of results for one
// byte combinationally and updates the window when the batch is taken.
module sfr_match #(
    parameter int KEY_MAX   = 8,
    parameter int VALUE_MAX = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  logic [sfr_pkg::BYTE_W-1:0]          in_byte,
    input  logic                                in_last,
    input  logic [sfr_pkg::REG_W-1:0]           key_bytes,
    input  logic [sfr_pkg::LEN_W-1:0]           key_length,
    input  logic [sfr_pkg::REG_W-1:0]           value_bytes,
    input  logic [sfr_pkg::LEN_W-1:0]           value_length,
    output sfr_pkg::sfr_step_t                  res
);

    localparam int KEY_LIM = (KEY_MAX < sfr_pkg::LANES) ? KEY_MAX : sfr_pkg::LANES;
    localparam int VAL_LIM = (VALUE_MAX < sfr_pkg::LANES) ? VALUE_MAX : sfr_pkg::LANES;
    localparam logic [sfr_pkg::LEN_W-1:0] KEY_LIM_L = sfr_pkg::LEN_W'(KEY_LIM);
    localparam logic [sfr_pkg::LEN_W-1:0] VAL_LIM_L = sfr_pkg::LEN_W'(VAL_LIM);

    // Window of pending bytes, oldest at index 0
    logic [sfr_pkg::BYTE_W-1:0] wnd_reg  [KEY_LIM];
    logic [sfr_pkg::BYTE_W-1:0] wnd_next [KEY_LIM];
    logic [sfr_pkg::LEN_W-1:0]  fill_reg, fill_next;
    logic [sfr_pkg::CNT_W-1:0]  total_reg, total_next;

    // Window with the new byte written in, padded with zero lanes
    logic [sfr_pkg::BYTE_W-1:0] win [sfr_pkg::LANES+2];
    logic [sfr_pkg::LANES-1:0]  lane_ok;
    logic [sfr_pkg::LANES-1:0][sfr_pkg::BYTE_W-1:0] out_bytes;

    logic [sfr_pkg::LEN_W-1:0]  klen, vlen, fill0, fill1;
    logic                       hit, drop1, drop2;
    logic [sfr_pkg::CNT_W-1:0]  total_inc;

    // Effective lengths after clamping
    always_comb
    begin
        if (key_length == '0)
            klen = sfr_pkg::LEN_W'(1);
        else if (key_length > KEY_LIM_L)
            klen = KEY_LIM_L;
        else
            klen = key_length;
        vlen = (value_length > VAL_LIM_L) ? VAL_LIM_L : value_length;
        fill0 = (fill_reg >= KEY_LIM_L) ? KEY_LIM_L - sfr_pkg::LEN_W'(1) : fill_reg;
        fill1 = fill0 + sfr_pkg::LEN_W'(1);
    end

    // Insert the byte and compare each lane with the key
    for (genvar g = 0; g < sfr_pkg::LANES + 2; g++)
    begin : g_lane
        if (g < KEY_LIM)
        begin : g_used
            assign win[g] = (fill0 == sfr_pkg::LEN_W'(g)) ? in_byte : wnd_reg[g];
            assign lane_ok[g] = (sfr_pkg::LEN_W'(g) >= klen) ||
                                (win[g] == key_bytes[g*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W]);
        end
        else
        begin : g_pad
            assign win[g] = '0;
            if (g < sfr_pkg::LANES)
            begin : g_ok
                assign lane_ok[g] = 1'b1;
            end
        end
    end

    // Result lanes: value bytes on a hit, otherwise the oldest window bytes
    for (genvar g = 0; g < sfr_pkg::LANES; g++)
    begin : g_out
        if (g < VAL_LIM)
        begin : g_val
            assign out_bytes[g] = hit ? value_bytes[g*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W]
                                      : win[g];
        end
        else
        begin : g_win
            assign out_bytes[g] = hit ? '0 : win[g];
        end
    end

    // Shifted window after emitting one or two bytes
    for (genvar g = 0; g < KEY_LIM; g++)
    begin : g_shift
        assign wnd_next[g] = drop2 ? win[g+2] : (drop1 ? win[g+1] : win[g]);
    end

    // Decision, counts and next state
    always_comb
    begin
        hit   = (fill1 == klen) && (&lane_ok);
        drop2 = !hit && !in_last && (fill1 > klen);
        drop1 = !hit && !in_last && (fill1 == klen);

        total_inc = (hit && total_reg != sfr_pkg::CNT_MAX)
                    ? total_reg + sfr_pkg::CNT_W'(1) : total_reg;

        res.bytes  = out_bytes;
        res.marker = hit && in_last && (vlen == '0);
        if (hit)
            res.count = res.marker ? sfr_pkg::LEN_W'(1) : vlen;
        else if (in_last)
            res.count = fill1;
        else if (drop2)
            res.count = sfr_pkg::LEN_W'(2);
        else if (drop1)
            res.count = sfr_pkg::LEN_W'(1);
        else
            res.count = '0;
        res.fin   = in_last;
        res.total = total_inc;
        res.found = (total_inc != '0);

        if (hit || in_last)
            fill_next = '0;
        else if (drop2)
            fill_next = fill1 - sfr_pkg::LEN_W'(2);
        else if (drop1)
            fill_next = fill1 - sfr_pkg::LEN_W'(1);
        else
            fill_next = fill1;

        total_next = in_last ? '0 : total_inc;
    end

    // Fill level and counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            total_reg <= '0;
        end
        else if (step)
        begin
            fill_reg  <= fill_next;
            total_reg <= total_next;
        end
    end

    // Window bytes, only read below the fill level
    always_ff @(posedge clk)
    begin
        if (step)
            wnd_reg <= wnd_next;
    end

endmodule

### sv/stream_find_and_replace.sv
// Streaming find and replace. Bytes enter on the slave stream, one per
// transaction, and every leftmost non-overlapping occurrence of the key
// (1 to 8 bytes) is replaced by the value (0 to 8 bytes); tlast on the
// input flushes the held bytes and the final output transaction carries
// tlast, the saturating replacement count and a found flag. If a stream
// ends with nothing to send, one end marker with tuser low goes out. Each
// input byte yields a batch of 0 to 8 bytes in the output buffer, which
// drains one byte per cycle while m_axis_tready is high; input is taken
// every cycle while batches have at most one byte and output is ready,
// and a larger batch holds input until its last byte is taken. The
// drain is the only limit on rate. The user must write configuration
// only while no stream transaction is in flight; it is not enforced.
module stream_find_and_replace #(
    parameter int KEY_MAX   = 8,
    parameter int VALUE_MAX = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // Configuration writes
    input  logic                              cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sfr_pkg::REG_W-1:0]         cfg_data,

    // Input byte stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [7:0] in_byte
    input  logic                              s_axis_tlast,   // in_last

    // Output byte stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [31:0]                       m_axis_tdata,   // [7:0] out_byte,
                                                              // [23:8] replacements,
                                                              // [24] key_found
    output logic                              m_axis_tuser,   // byte_valid
    output logic                              m_axis_tlast    // out_last
);

    // Configuration registers
    logic [sfr_pkg::REG_W-1:0] key_bytes_reg, value_bytes_reg;
    logic [sfr_pkg::LEN_W-1:0] key_length_reg, value_length_reg;

    // Input register
    logic                       in_vld_reg;
    logic [sfr_pkg::BYTE_W-1:0] in_byte_reg;
    logic                       in_last_reg;

    // Output buffer
    logic [sfr_pkg::BYTE_W-1:0] buf_reg [sfr_pkg::LANES];
    logic [sfr_pkg::LEN_W-1:0]  rem_reg;
    logic [sfr_pkg::PTR_W-1:0]  ptr_reg;
    logic                       marker_reg, fin_reg, found_reg;
    logic [sfr_pkg::CNT_W-1:0]  total_reg;

    sfr_pkg::sfr_step_t         res;
    logic                       s_take, m_take, fire, last_beat;

    // Handshakes
    always_comb
    begin
        m_take        = m_axis_tvalid && m_axis_tready;
        fire          = in_vld_reg &&
                        ((rem_reg == '0) || ((rem_reg == sfr_pkg::LEN_W'(1)) && m_axis_tready));
        s_axis_tready = !in_vld_reg || fire;
        s_take        = s_axis_tvalid && s_axis_tready;
    end

    // Configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_bytes_reg    <= '0;
            key_length_reg   <= sfr_pkg::LEN_W'(1);
            value_bytes_reg  <= '0;
            value_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sfr_pkg::REG_KEY_BYTES:    key_bytes_reg    <= cfg_data;
                sfr_pkg::REG_KEY_LENGTH:   key_length_reg   <= cfg_data[sfr_pkg::LEN_W-1:0];
                sfr_pkg::REG_VALUE_BYTES:  value_bytes_reg  <= cfg_data;
                sfr_pkg::REG_VALUE_LENGTH: value_length_reg <= cfg_data[sfr_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (s_take)
            in_vld_reg <= 1'b1;
        else if (fire)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    sfr_match #(
        .KEY_MAX   (KEY_MAX),
        .VALUE_MAX (VALUE_MAX)
    ) u_match (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (fire),
        .in_byte      (in_byte_reg),
        .in_last      (in_last_reg),
        .key_bytes    (key_bytes_reg),
        .key_length   (key_length_reg),
        .value_bytes  (value_bytes_reg),
        .value_length (value_length_reg),
        .res          (res)
    );

    // Output buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            ptr_reg <= '0;
        end
        else if (fire)
        begin
            rem_reg <= res.count;
            ptr_reg <= '0;
        end
        else if (m_take)
        begin
            rem_reg <= rem_reg - sfr_pkg::LEN_W'(1);
            ptr_reg <= ptr_reg + sfr_pkg::PTR_W'(1);
        end
    end

    // Output buffer payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            for (int i = 0; i < sfr_pkg::LANES; i++)
                buf_reg[i] <= res.bytes[i];
            marker_reg <= res.marker;
            fin_reg    <= res.fin;
            total_reg  <= res.total;
            found_reg  <= res.found;
        end
    end

    // Output fields; stream totals only on the closing transaction
    always_comb
    begin
        last_beat     = (rem_reg == sfr_pkg::LEN_W'(1)) && fin_reg;
        m_axis_tvalid = (rem_reg != '0);
        m_axis_tuser  = !marker_reg;
        m_axis_tlast  = last_beat;
        m_axis_tdata  = '0;
        m_axis_tdata[7:0]   = marker_reg ? '0 : buf_reg[ptr_reg];
        m_axis_tdata[23:8]  = last_beat ? total_reg : '0;
        m_axis_tdata[24]    = last_beat && found_reg;
    end

endmodule
